/* sv/afc_pkg.sv */
// Package for the box-versus-frustum classifier.
// Holds the fixed-point widths, the register map, the plane and camera layouts and the verdict codes.
// No dependencies.
package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int POS_W     = 20;
  localparam int REL_W     = POS_W + 1;
  localparam int HALF_W    = 18;
  localparam int NRM_W     = 12;
  localparam int OFF_W     = 28;
  localparam int OFF_SHIFT = 10;
  localparam int CAM_W     = 3 * POS_W;
  localparam int PROD_W    = REL_W + NRM_W;
  localparam int EXT_W     = HALF_W + NRM_W;
  localparam int RAD_W     = EXT_W + 2;
  localparam int DIST_W    = 41;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA = 3'd6;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE   = 2'd0,
    VERDICT_INSIDE    = 2'd1,
    VERDICT_INTERSECT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] offset;
    logic signed [NRM_W-1:0] nz;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } camera_t;

  typedef struct packed {
    logic signed [REL_W-1:0] z;
    logic signed [REL_W-1:0] y;
    logic signed [REL_W-1:0] x;
  } rel_t;

  typedef struct packed {
    logic [HALF_W-1:0] z;
    logic [HALF_W-1:0] y;
    logic [HALF_W-1:0] x;
  } half_t;

  typedef struct packed {
    logic reject;
    logic straddle;
  } plane_flags_t;

  function automatic logic [NRM_W-1:0] abs_nrm(input logic signed [NRM_W-1:0] v);
    logic signed [NRM_W-1:0] neg;
    neg = -v;
    return v[NRM_W-1] ? NRM_W'(neg) : NRM_W'(v);
  endfunction

endpackage

/* sv/afc_plane_eval.sv */
// One plane lane: signed distance of the box center and projected radius of the box.
// Flags a plane that rejects the box and one that the box straddles.
// Depends on afc_pkg.
module afc_plane_eval (
  input  afc_pkg::rel_t         rel,
  input  afc_pkg::half_t        half,
  input  afc_pkg::plane_t       plane,
  output afc_pkg::plane_flags_t flags
);

  logic signed [afc_pkg::PROD_W-1:0] px, py, pz;
  logic [afc_pkg::NRM_W-1:0]         ax, ay, az;
  logic [afc_pkg::EXT_W-1:0]         ex, ey, ez;
  logic [afc_pkg::RAD_W-1:0]         rad;
  logic signed [afc_pkg::DIST_W-1:0] sdist, rad_s, far_d, near_d;

  assign px = afc_pkg::PROD_W'(rel.x) * afc_pkg::PROD_W'(plane.nx);
  assign py = afc_pkg::PROD_W'(rel.y) * afc_pkg::PROD_W'(plane.ny);
  assign pz = afc_pkg::PROD_W'(rel.z) * afc_pkg::PROD_W'(plane.nz);

  assign ax = afc_pkg::abs_nrm(plane.nx);
  assign ay = afc_pkg::abs_nrm(plane.ny);
  assign az = afc_pkg::abs_nrm(plane.nz);

  assign ex = afc_pkg::EXT_W'(half.x) * afc_pkg::EXT_W'(ax);
  assign ey = afc_pkg::EXT_W'(half.y) * afc_pkg::EXT_W'(ay);
  assign ez = afc_pkg::EXT_W'(half.z) * afc_pkg::EXT_W'(az);

  assign rad = afc_pkg::RAD_W'(ex) + afc_pkg::RAD_W'(ey) + afc_pkg::RAD_W'(ez);

  assign sdist = afc_pkg::DIST_W'(px) + afc_pkg::DIST_W'(py) + afc_pkg::DIST_W'(pz)
               + (afc_pkg::DIST_W'(plane.offset) <<< afc_pkg::OFF_SHIFT);
  assign rad_s  = signed'(afc_pkg::DIST_W'(rad));
  assign far_d  = sdist + rad_s;
  assign near_d = sdist - rad_s;

  assign flags.reject   = far_d[afc_pkg::DIST_W-1];
  assign flags.straddle = near_d[afc_pkg::DIST_W-1];

endmodule

/* sv/afc_cfg_regs.sv */
// Configuration registers: the frustum planes and the camera position.
// Writes to unused plane slots or unknown indexes are dropped.
// Depends on afc_pkg.
module afc_cfg_regs #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0] cfg_data,
  output afc_pkg::plane_t                planes [PLANE_COUNT],
  output afc_pkg::camera_t               camera
);

  afc_pkg::plane_t  planes_r [PLANE_COUNT];
  afc_pkg::camera_t camera_r;

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        planes_r[i] <= '0;
      end else if (cfg_we && cfg_index == afc_pkg::CFG_IDX_W'(i)) begin
        planes_r[i] <= afc_pkg::plane_t'(cfg_data);
      end
    end
    assign planes[i] = planes_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_r <= '0;
    end else if (cfg_we && cfg_index == afc_pkg::REG_CAMERA) begin
      camera_r <= afc_pkg::camera_t'(cfg_data[afc_pkg::CAM_W-1:0]);
    end
  end

  assign camera = camera_r;

endmodule

/* sv/aabb_frustum_classifier.sv */
// Top level of the box-versus-frustum classifier.
// Instantiates the configuration registers and one evaluation lane per plane.
// Depends on afc_pkg, afc_cfg_regs and afc_plane_eval.
//
// The input channel carries one box per transaction: a signed Q12.8 center and
// unsigned Q10.8 half-extents. A transaction completes on a clock edge with
// in_valid high and in_stall low. The output channel returns one verdict per
// box, in order: outside, fully inside or intersecting the frustum boundary.
// The block takes one box per clock while out_stall is low. The camera offset
// is subtracted as the box is captured; all planes are then tested in parallel
// lanes between the input register and the result register, which drives the
// verdict onto the port. When the receiver holds out_stall, the verdict stays
// on the port and one more box may be captured behind it; in_stall rises only
// when both stages are full and the output is stalled.
// Reset clears both valid flags, all planes and the camera position; with all
// planes zero every box is classified as inside. Planes and camera must be
// written through the cfg port only while no box is in flight; the block itself
// does not enforce this.
module aabb_frustum_classifier #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [afc_pkg::POS_W-1:0]      in_center_x,
  input  logic signed [afc_pkg::POS_W-1:0]      in_center_y,
  input  logic signed [afc_pkg::POS_W-1:0]      in_center_z,
  input  logic [afc_pkg::HALF_W-1:0]            in_half_x,
  input  logic [afc_pkg::HALF_W-1:0]            in_half_y,
  input  logic [afc_pkg::HALF_W-1:0]            in_half_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_verdict,
  input  logic                                  cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  afc_pkg::plane_t       planes [PLANE_COUNT];
  afc_pkg::camera_t      camera;
  afc_pkg::plane_flags_t lane_flags [PLANE_COUNT];

  logic             s1_valid_r;
  afc_pkg::rel_t    s1_rel_r, rel_nxt;
  afc_pkg::half_t   s1_half_r;
  logic             out_valid_r;
  afc_pkg::verdict_t out_verdict_r, verdict_nxt;

  logic out_adv, s1_adv, accept;
  logic reject_any, straddle_any;

  afc_cfg_regs #(
    .PLANE_COUNT(PLANE_COUNT)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .planes   (planes),
    .camera   (camera)
  );

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;
  assign accept   = in_valid && s1_adv;

  assign rel_nxt.x = afc_pkg::REL_W'(in_center_x) - afc_pkg::REL_W'(camera.x);
  assign rel_nxt.y = afc_pkg::REL_W'(in_center_y) - afc_pkg::REL_W'(camera.y);
  assign rel_nxt.z = afc_pkg::REL_W'(in_center_z) - afc_pkg::REL_W'(camera.z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rel_r  <= rel_nxt;
      s1_half_r <= '{z: in_half_z, y: in_half_y, x: in_half_x};
    end
    if (out_adv && s1_valid_r) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
    afc_plane_eval u_plane_eval (
      .rel  (s1_rel_r),
      .half (s1_half_r),
      .plane(planes[i]),
      .flags(lane_flags[i])
    );
  end

  always_comb begin
    reject_any   = 1'b0;
    straddle_any = 1'b0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      reject_any   = reject_any | lane_flags[i].reject;
      straddle_any = straddle_any | lane_flags[i].straddle;
    end
    if (reject_any) begin
      verdict_nxt = afc_pkg::VERDICT_OUTSIDE;
    end else if (straddle_any) begin
      verdict_nxt = afc_pkg::VERDICT_INTERSECT;
    end else begin
      verdict_nxt = afc_pkg::VERDICT_INSIDE;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

/* sv/afc_checker.sv */
// Port-level checks for the box-versus-frustum classifier.
// Bound to aabb_frustum_classifier; uses only its ports.
module afc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict
);

  // A stalled verdict stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict))
    else $error("stalled verdict changed or was dropped");

  // The input side backs up only when a stalled verdict waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  // A captured box reaches the port as a valid verdict once out_stall is low after it is taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("verdict did not appear after an accepted box");

  // The verdict is never the unused code.
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != 2'd3)
    else $error("unused verdict code on the output");

endmodule

bind aabb_frustum_classifier afc_checker u_afc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_verdict(out_verdict)
);

/* test/tb_aabb_frustum_classifier.sv */
// Testbench for aabb_frustum_classifier: random and directed boxes against plane sets.
// A queue-fed driver and a checking monitor compare every verdict with an in-bench predictor.
// Depends on afc_pkg and the aabb_frustum_classifier RTL.
module tb_aabb_frustum_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import afc_pkg::*;

  localparam int LIMIT_NS    = 200000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BOXES = 50;
  localparam int NOISE_PCT   = 15;
  localparam int LONG_HOLD   = 300;
  localparam int NRM_ONE     = 1 << (NRM_W - 2);
  localparam int NRM_MAX     = (1 << (NRM_W - 1)) - 1;
  localparam int NRM_MIN     = -(1 << (NRM_W - 1));
  localparam int OFF_MAX     = (1 << (OFF_W - 1)) - 1;
  localparam int OFF_MIN     = -(1 << (OFF_W - 1));
  localparam int POS_MAX     = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN     = -(1 << (POS_W - 1));
  localparam int HALF_MAX    = (1 << HALF_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 3'd7;

  typedef enum int {
    STYLE_AXIS    = 0,
    STYLE_NORMALS = 1,
    STYLE_SPARSE  = 2,
    STYLE_RAW     = 3
  } setting_style_t;

  typedef struct packed {
    logic [POS_W-1:0]  cx;
    logic [POS_W-1:0]  cy;
    logic [POS_W-1:0]  cz;
    logic [HALF_W-1:0] hx;
    logic [HALF_W-1:0] hy;
    logic [HALF_W-1:0] hz;
  } box_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [POS_W-1:0]       in_center_x = '0;
  logic [POS_W-1:0]       in_center_y = '0;
  logic [POS_W-1:0]       in_center_z = '0;
  logic [HALF_W-1:0]      in_half_x = '0;
  logic [HALF_W-1:0]      in_half_y = '0;
  logic [HALF_W-1:0]      in_half_z = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_verdict;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  plane_t    plane_mirror [NUM_PLANES];
  camera_t   camera_mirror;
  plane_t    plane_next [NUM_PLANES];
  camera_t   cam_next;

  box_t      box_q [$];
  verdict_t  verdict_q [$];
  box_t      box_on_port;
  verdict_t  want;

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      send_hold = 1'b0;
  logic      recv_hold = 1'b0;
  int        fail_count = 0;
  int        boxes_sent = 0;
  int        results_seen = 0;
  int        settings_done = 0;
  int        verdict_tally [3] = '{0, 0, 0};

  always #1 clk = ~clk;

  aabb_frustum_classifier u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_center_z (in_center_z),
    .in_half_x   (in_half_x),
    .in_half_y   (in_half_y),
    .in_half_z   (in_half_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic verdict_t classify(box_t b);
    longint   rx, ry, rz, nx, ny, nz, d, r;
    int       i;
    verdict_t v;
    v  = VERDICT_INSIDE;
    rx = longint'($signed(b.cx)) - longint'(camera_mirror.x);
    ry = longint'($signed(b.cy)) - longint'(camera_mirror.y);
    rz = longint'($signed(b.cz)) - longint'(camera_mirror.z);
    for (i = 0; i < NUM_PLANES; i++) begin
      if (v != VERDICT_OUTSIDE) begin
        nx = longint'(plane_mirror[i].nx);
        ny = longint'(plane_mirror[i].ny);
        nz = longint'(plane_mirror[i].nz);
        d  = rx * nx + ry * ny + rz * nz
           + (longint'(plane_mirror[i].offset) <<< OFF_SHIFT);
        r  = longint'(b.hx) * (nx < 0 ? -nx : nx)
           + longint'(b.hy) * (ny < 0 ? -ny : ny)
           + longint'(b.hz) * (nz < 0 ? -nz : nz);
        if (d + r < 0) begin
          v = VERDICT_OUTSIDE;
        end else if (d - r < 0) begin
          v = VERDICT_INTERSECT;
        end
      end
    end
    return v;
  endfunction

  function automatic plane_t make_plane(int nx, int ny, int nz, int off);
    plane_t p;
    p.nx     = NRM_W'(nx);
    p.ny     = NRM_W'(ny);
    p.nz     = NRM_W'(nz);
    p.offset = OFF_W'(off);
    return p;
  endfunction

  function automatic box_t mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
    box_t b;
    b.cx = POS_W'(cx);
    b.cy = POS_W'(cy);
    b.cz = POS_W'(cz);
    b.hx = HALF_W'(hx);
    b.hy = HALF_W'(hy);
    b.hz = HALF_W'(hz);
    return b;
  endfunction

  function automatic box_t near_box(int span);
    box_t b;
    b.cx = POS_W'(int'(camera_mirror.x) + int'($urandom_range(4 * span)) - 2 * span);
    b.cy = POS_W'(int'(camera_mirror.y) + int'($urandom_range(4 * span)) - 2 * span);
    b.cz = POS_W'(int'(camera_mirror.z) + int'($urandom_range(4 * span)) - 2 * span);
    if ($urandom_range(4) == 0) begin
      b.hx = '0;
      b.hy = '0;
      b.hz = '0;
    end else begin
      b.hx = HALF_W'($urandom_range(span));
      b.hy = HALF_W'($urandom_range(span));
      b.hz = HALF_W'($urandom_range(span));
    end
    return b;
  endfunction

  function automatic box_t noise_box();
    box_t b;
    b.cx = POS_W'($urandom);
    b.cy = POS_W'($urandom);
    b.cz = POS_W'($urandom);
    b.hx = HALF_W'($urandom);
    b.hy = HALF_W'($urandom);
    b.hz = HALF_W'($urandom);
    return b;
  endfunction

  function automatic int pick_offset(int span);
    return span / 2 + int'($urandom_range(span / 2));
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx < NUM_PLANES) begin
      plane_mirror[idx] = data;
    end else if (idx == REG_CAMERA) begin
      camera_mirror = data[CAM_W-1:0];
    end
  endtask

  task automatic apply_setting();
    int i;
    for (i = 0; i < NUM_PLANES; i++) begin
      cfg_write(CFG_IDX_W'(int'(REG_PLANE_TOP) + i), plane_next[i]);
    end
    cfg_write(REG_CAMERA, {4'($urandom), cam_next});
    if ($urandom_range(1) == 1) begin
      cfg_write(REG_SPARE, {$urandom, $urandom});
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic set_axis_frustum(int span, bit sparse);
    int i;
    plane_next[REG_PLANE_TOP]    = make_plane(0, -NRM_ONE, 0, pick_offset(span));
    plane_next[REG_PLANE_BOTTOM] = make_plane(0, NRM_ONE, 0, pick_offset(span));
    plane_next[REG_PLANE_LEFT]   = make_plane(NRM_ONE, 0, 0, pick_offset(span));
    plane_next[REG_PLANE_RIGHT]  = make_plane(-NRM_ONE, 0, 0, pick_offset(span));
    plane_next[REG_PLANE_NEAR]   = make_plane(0, 0, NRM_ONE, pick_offset(span));
    plane_next[REG_PLANE_FAR]    = make_plane(0, 0, -NRM_ONE, pick_offset(span));
    if (sparse) begin
      for (i = 0; i < NUM_PLANES; i++) begin
        if ($urandom_range(2) == 0) plane_next[i] = '0;
      end
    end
  endtask

  task automatic set_random_camera();
    cam_next.x = POS_W'($urandom);
    cam_next.y = POS_W'($urandom);
    cam_next.z = POS_W'($urandom);
  endtask

  task automatic drain();
    wait (box_q.size() == 0);
    @(posedge clk);
    wait (!in_valid && verdict_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_random(int span, int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < NOISE_PCT) box_q.push_back(noise_box());
      else box_q.push_back(near_box(span));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(classify(box_on_port));
        boxes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (box_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
          box_on_port = box_q.pop_front();
          in_center_x <= box_on_port.cx;
          in_center_y <= box_on_port.cy;
          in_center_z <= box_on_port.cz;
          in_half_x   <= box_on_port.hx;
          in_half_y   <= box_on_port.hy;
          in_half_z   <= box_on_port.hz;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict transaction, expected none actual %0d",
                   $time, out_verdict);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want) begin
            $display("%0t: verdict mismatch, expected %s (%0d) actual %0d",
                     $time, want.name(), want, out_verdict);
            fail_count++;
          end else begin
            verdict_tally[int'(want)]++;
          end
        end
      end
      out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    int             ph;
    int             span;
    int             i;
    setting_style_t style;
    for (i = 0; i < NUM_PLANES; i++) plane_mirror[i] = '0;
    camera_mirror = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 62;
    box_q.push_back(mk_box(0, 0, 0, 0, 0, 0));
    box_q.push_back(mk_box(POS_MAX, POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    box_q.push_back(mk_box(POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    box_q.push_back(mk_box(POS_MIN, POS_MAX, 0, HALF_MAX, 0, 1));
    drain();

    for (i = 0; i < NUM_PLANES; i++) plane_next[i] = '0;
    plane_next[REG_PLANE_TOP]    = make_plane(0, -NRM_ONE, 0, 2560);
    plane_next[REG_PLANE_BOTTOM] = make_plane(0, NRM_ONE, 0, 2560);
    plane_next[REG_PLANE_LEFT]   = make_plane(NRM_ONE, 0, 0, 2560);
    plane_next[REG_PLANE_RIGHT]  = make_plane(-NRM_ONE, 0, 0, 2560);
    plane_next[REG_PLANE_NEAR]   = make_plane(0, 0, NRM_ONE, 2560);
    plane_next[REG_PLANE_FAR]    = make_plane(0, 0, -NRM_ONE, 2560);
    cam_next.x = POS_W'(256);
    cam_next.y = POS_W'(-512);
    cam_next.z = POS_W'(1024);
    apply_setting();
    box_q.push_back(mk_box(256, -512, 1024, 0, 0, 0));
    box_q.push_back(mk_box(256 + 2560, -512, 1024, 0, 0, 0));
    box_q.push_back(mk_box(256 + 2561, -512, 1024, 0, 0, 0));
    box_q.push_back(mk_box(256, -512 + 2561, 1024, 0, 0, 0));
    box_q.push_back(mk_box(256, -512, 1024 - 2561, 0, 0, 0));
    box_q.push_back(mk_box(256, -512, 1024, 2560, 2560, 2560));
    box_q.push_back(mk_box(256, -512, 1024, 2561, 0, 0));
    box_q.push_back(mk_box(256 + 3000, -512, 1024, 440, 0, 0));
    box_q.push_back(mk_box(256 + 3000, -512, 1024, 439, 0, 0));
    box_q.push_back(mk_box(256, -512, 1024, HALF_MAX, HALF_MAX, HALF_MAX));
    drain();

    for (i = 0; i < NUM_PLANES; i++) plane_next[i] = make_plane(NRM_MIN, NRM_MIN, NRM_MIN, OFF_MAX);
    cam_next.x = POS_W'(POS_MIN);
    cam_next.y = POS_W'(POS_MIN);
    cam_next.z = POS_W'(POS_MIN);
    apply_setting();
    box_q.push_back(mk_box(POS_MAX, POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    box_q.push_back(mk_box(POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    box_q.push_back(mk_box(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
    drain();

    for (i = 0; i < NUM_PLANES; i++) plane_next[i] = make_plane(NRM_MAX, NRM_MAX, NRM_MAX, OFF_MIN);
    cam_next.x = POS_W'(POS_MAX);
    cam_next.y = POS_W'(POS_MAX);
    cam_next.z = POS_W'(POS_MAX);
    apply_setting();
    box_q.push_back(mk_box(POS_MAX, POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    box_q.push_back(mk_box(POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    box_q.push_back(mk_box(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 62;
      end else if (ph < 6) begin
        send_idle_pct = 62;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      span  = int'($urandom_range(100000, 500));
      style = setting_style_t'(ph % 4);
      set_random_camera();
      case (style)
        STYLE_AXIS: begin
          set_axis_frustum(span, 1'b0);
        end
        STYLE_SPARSE: begin
          set_axis_frustum(span, 1'b1);
        end
        STYLE_NORMALS: begin
          for (i = 0; i < NUM_PLANES; i++) begin
            plane_next[i] = make_plane(int'($urandom_range(2 * NRM_ONE)) - NRM_ONE,
                                       int'($urandom_range(2 * NRM_ONE)) - NRM_ONE,
                                       int'($urandom_range(2 * NRM_ONE)) - NRM_ONE,
                                       int'($urandom_range(span + span / 4)) - span / 4);
          end
        end
        default: begin
          for (i = 0; i < NUM_PLANES; i++) plane_next[i] = {$urandom, $urandom};
        end
      endcase
      apply_setting();
      if (ph == 6) begin
        push_random(span, PHASE_BOXES);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        recv_hold <= 1'b0;
      end else if (ph == 7) begin
        push_random(span, PHASE_BOXES / 2);
        wait (box_q.size() == 0);
        @(posedge clk);
        send_hold <= 1'b1;
        @(posedge clk);
        wait (!in_valid && verdict_q.size() == 0);
        repeat (5) @(posedge clk);
        send_hold <= 1'b0;
        push_random(span, PHASE_BOXES - PHASE_BOXES / 2);
      end else begin
        push_random(span, PHASE_BOXES);
      end
      drain();
    end

    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts still expected, actual none", $time, verdict_q.size());
      fail_count++;
    end
    $display("Checked %0d verdicts for %0d boxes over %0d register settings.",
             results_seen, boxes_sent, settings_done);
    $display("Matched %0d outside, %0d inside and %0d intersecting verdicts.",
             verdict_tally[VERDICT_OUTSIDE], verdict_tally[VERDICT_INSIDE],
             verdict_tally[VERDICT_INTERSECT]);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
sv/afc_pkg.sv
sv/afc_plane_eval.sv
sv/afc_cfg_regs.sv
sv/aabb_frustum_classifier.sv
sv/afc_checker.sv
test/tb_aabb_frustum_classifier.sv
